[design/lpp_pkg.sv]
// Package: widths, angle constants, arctangent table and the rotation stage record.
`timescale 1ns / 1ps

package lpp_pkg;

    // Stage count of the rotation chain, limited by the arctangent table
    localparam int ROTATION_STAGES = 16;
    localparam int TABLE_LEN       = 24;
    localparam int NUM_CELLS       = (ROTATION_STAGES < TABLE_LEN) ? ROTATION_STAGES : TABLE_LEN;
    localparam int STAGE_W         = $clog2(TABLE_LEN);

    // Field widths
    localparam int COORD_W = 24;
    localparam int DIST_W  = 16;
    localparam int ANG_W   = 15;

    // Internal widths
    localparam int ANG_S_W  = ANG_W + 1;          // signed angle difference
    localparam int Z_SH     = 16;                 // residual angle scale
    localparam int Z_W      = ANG_S_W + Z_SH;     // residual angle in 2^-22 degree
    localparam int GAIN_W   = 16;
    localparam int PROD_W   = DIST_W + GAIN_W;
    localparam int VEC_W    = PROD_W + 3;         // rotated vector, with headroom for gain
    localparam int ROUND_SH = 16;                 // Q16 millimetres back to millimetres

    // Constants
    localparam logic [GAIN_W-1:0] GAIN_Q16     = 16'd39797;
    localparam logic [DIST_W-1:0] MAX_DIST_RST = 16'd2000;
    localparam logic [ANG_W-1:0]  FULL_TURN    = 15'd23040;
    localparam logic signed [ANG_S_W-1:0] FULL_TURN_S    = 16'sd23040;
    localparam logic signed [ANG_S_W-1:0] HALF_TURN_S    = 16'sd11520;
    localparam logic signed [ANG_S_W-1:0] QUARTER_TURN_S = 16'sd5760;
    localparam int COORD_MAX = 8388607;
    localparam int COORD_MIN = -8388608;

    // Operation codes
    localparam logic OP_POSE = 1'b0;
    localparam logic OP_MEAS = 1'b1;

    // One item in flight through the rotation chain
    typedef struct packed {
        logic                      valid;
        logic                      kept;
        logic                      last;
        logic signed [VEC_W-1:0]   x;
        logic signed [VEC_W-1:0]   y;
        logic signed [Z_W-1:0]     z;
        logic signed [COORD_W-1:0] hx;
        logic signed [COORD_W-1:0] hy;
    } t_rot;

    // atan(2^-i) in 2^-22 degree, rounded
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [STAGE_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        begin
            unique case (idx)
                5'd0:    v = 32'sd188743680;
                5'd1:    v = 32'sd111421900;
                5'd2:    v = 32'sd58872272;
                5'd3:    v = 32'sd29884485;
                5'd4:    v = 32'sd15000234;
                5'd5:    v = 32'sd7507429;
                5'd6:    v = 32'sd3754631;
                5'd7:    v = 32'sd1877430;
                5'd8:    v = 32'sd938729;
                5'd9:    v = 32'sd469366;
                5'd10:   v = 32'sd234683;
                5'd11:   v = 32'sd117342;
                5'd12:   v = 32'sd58671;
                5'd13:   v = 32'sd29335;
                5'd14:   v = 32'sd14668;
                5'd15:   v = 32'sd7334;
                5'd16:   v = 32'sd3667;
                5'd17:   v = 32'sd1833;
                5'd18:   v = 32'sd917;
                5'd19:   v = 32'sd458;
                5'd20:   v = 32'sd229;
                5'd21:   v = 32'sd115;
                5'd22:   v = 32'sd57;
                5'd23:   v = 32'sd29;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

[design/lpp_cfg_if.sv]
// Interface: configuration write channel carrying the distance limit.
`timescale 1ns / 1ps

interface lpp_cfg_if;
    import lpp_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] max_distance;

    modport source (output valid, output max_distance, input ready);
    modport sink   (input valid, input max_distance, output ready);
endinterface

[design/lpp_in_if.sv]
// Interface: input channel carrying pose loads and range measurements.
`timescale 1ns / 1ps

interface lpp_in_if;
    import lpp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic signed [COORD_W-1:0] pose_x;
    logic signed [COORD_W-1:0] pose_y;
    logic [ANG_W-1:0]          pose_heading;
    logic [DIST_W-1:0]         distance;
    logic [ANG_W-1:0]          scan_angle;
    logic                      scan_end;

    modport source (output valid, output operation, output pose_x, output pose_y,
                    output pose_heading, output distance, output scan_angle,
                    output scan_end, input ready);
    modport sink   (input valid, input operation, input pose_x, input pose_y,
                    input pose_heading, input distance, input scan_angle,
                    input scan_end, output ready);
endinterface

[design/lpp_out_if.sv]
// Interface: output channel carrying projected points.
`timescale 1ns / 1ps

interface lpp_out_if;
    import lpp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      kept;
    logic                      last_of_scan;

    modport source (output valid, output point_x, output point_y, output kept,
                    output last_of_scan, input ready);
    modport sink   (input valid, input point_x, input point_y, input kept,
                    input last_of_scan, output ready);
endinterface

[design/lpp_front.sv]
// Front stage: angle reduction, quadrant pre-rotation and gain-scaled distance.
`timescale 1ns / 1ps

module lpp_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [lpp_pkg::DIST_W-1:0]        i_distance,
    input  logic [lpp_pkg::ANG_W-1:0]         i_scan_angle,
    input  logic                              i_scan_end,
    input  logic [lpp_pkg::ANG_W-1:0]         i_heading,
    input  logic signed [lpp_pkg::COORD_W-1:0] i_hx,
    input  logic signed [lpp_pkg::COORD_W-1:0] i_hy,
    input  logic [lpp_pkg::DIST_W-1:0]        i_max_distance,
    output lpp_pkg::t_rot                     o_rot
);
    import lpp_pkg::*;

    logic [ANG_W-1:0]          h_red;
    logic [ANG_W-1:0]          s_red;
    logic signed [ANG_S_W-1:0] diff;
    logic signed [ANG_S_W-1:0] wrapped;
    logic signed [ANG_S_W-1:0] resid;
    logic [PROD_W-1:0]         prod;
    logic signed [VEC_W-1:0]   d_s;
    t_rot                      n_rot;
    t_rot                      r_rot;

    // Reduce both angles into one turn
    assign h_red = (i_heading >= FULL_TURN) ? i_heading - FULL_TURN : i_heading;
    assign s_red = (i_scan_angle >= FULL_TURN) ? i_scan_angle - FULL_TURN : i_scan_angle;

    // Scaled distance: distance times the inverse rotation gain in Q16
    assign prod = PROD_W'(i_distance) * PROD_W'(GAIN_Q16);
    assign d_s  = $signed({{(VEC_W-PROD_W){1'b0}}, prod});

    // Heading minus scan angle, moved into half-open range around zero
    always_comb begin
        diff    = $signed({1'b0, h_red}) - $signed({1'b0, s_red});
        wrapped = diff;
        if (diff < 0) begin
            wrapped = diff + FULL_TURN_S;
        end
        if (wrapped > HALF_TURN_S) begin
            wrapped = wrapped - FULL_TURN_S;
        end
    end

    // Pre-rotate by a quarter turn when outside the convergence range
    always_comb begin
        n_rot       = '0;
        n_rot.valid = i_valid;
        n_rot.kept  = (i_distance <= i_max_distance);
        n_rot.last  = i_scan_end;
        n_rot.hx    = i_hx;
        n_rot.hy    = i_hy;
        priority if (wrapped > QUARTER_TURN_S) begin
            n_rot.x = '0;
            n_rot.y = d_s;
            resid   = wrapped - QUARTER_TURN_S;
        end else if (wrapped < -QUARTER_TURN_S) begin
            n_rot.x = '0;
            n_rot.y = -d_s;
            resid   = wrapped + QUARTER_TURN_S;
        end else begin
            n_rot.x = d_s;
            n_rot.y = '0;
            resid   = wrapped;
        end
        n_rot.z = {resid, {Z_SH{1'b0}}};
    end

    // Advance on pipeline enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot.valid <= 1'b0;
        end else if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;

endmodule

[design/lpp_cell.sv]
// Rotation cell: one micro-rotation of the vector and residual angle.
`timescale 1ns / 1ps

module lpp_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [lpp_pkg::STAGE_W-1:0]  i_stage,
    input  lpp_pkg::t_rot                i_rot,
    output lpp_pkg::t_rot                o_rot
);
    import lpp_pkg::*;

    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    logic signed [Z_W-1:0]   step;
    t_rot                    n_rot;
    t_rot                    r_rot;

    // Shifted cross terms and this cell's angle step
    assign dx   = $signed(i_rot.y) >>> i_stage;
    assign dy   = $signed(i_rot.x) >>> i_stage;
    assign step = atan_entry(i_stage);

    // Rotate toward zero residual angle
    always_comb begin
        n_rot = i_rot;
        if (!i_rot.z[Z_W-1]) begin
            n_rot.x = i_rot.x - dx;
            n_rot.y = i_rot.y + dy;
            n_rot.z = i_rot.z - step;
        end else begin
            n_rot.x = i_rot.x + dx;
            n_rot.y = i_rot.y - dy;
            n_rot.z = i_rot.z + step;
        end
    end

    // Hand the item to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot.valid <= 1'b0;
        end else if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;

endmodule

[design/lpp_place.sv]
// Output stage: round, add the held pose, saturate and hold the result beat.
`timescale 1ns / 1ps

module lpp_place (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  lpp_pkg::t_rot                      i_rot,
    output logic                               o_valid,
    output logic signed [lpp_pkg::COORD_W-1:0] o_point_x,
    output logic signed [lpp_pkg::COORD_W-1:0] o_point_y,
    output logic                               o_kept,
    output logic                               o_last
);
    import lpp_pkg::*;

    localparam int OFF_W = VEC_W + 1 - ROUND_SH;
    localparam int SUM_W = COORD_W + 2;
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(COORD_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(COORD_MIN);

    logic signed [COORD_W-1:0] n_px;
    logic signed [COORD_W-1:0] n_py;
    logic                      r_valid;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic                      r_kept;
    logic                      r_last;

    // Round to millimetres, add held coordinate, clamp to coordinate range
    function automatic logic signed [COORD_W-1:0] place_axis(
        input logic signed [VEC_W-1:0]   v,
        input logic signed [COORD_W-1:0] held
    );
        logic signed [VEC_W:0]     rnd;
        logic signed [OFF_W-1:0]   off;
        logic signed [SUM_W-1:0]   sum;
        logic signed [COORD_W-1:0] res;
        begin
            rnd = {v[VEC_W-1], v} + (VEC_W+1)'(1 << (ROUND_SH - 1));
            off = rnd[VEC_W:ROUND_SH];
            sum = {{(SUM_W-COORD_W){held[COORD_W-1]}}, held}
                + {{(SUM_W-OFF_W){off[OFF_W-1]}}, off};
            if (sum > SUM_MAX) begin
                res = SUM_MAX[COORD_W-1:0];
            end else if (sum < SUM_MIN) begin
                res = SUM_MIN[COORD_W-1:0];
            end else begin
                res = sum[COORD_W-1:0];
            end
            return res;
        end
    endfunction

    // Zero the coordinates of a dropped measurement
    assign n_px = i_rot.kept ? place_axis(i_rot.x, i_rot.hx) : '0;
    assign n_py = i_rot.kept ? place_axis(i_rot.y, i_rot.hy) : '0;

    // Output register: load on enable, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_rot.valid;
            r_px    <= n_px;
            r_py    <= n_py;
            r_kept  <= i_rot.kept;
            r_last  <= i_rot.last;
        end
    end

    assign o_valid   = r_valid;
    assign o_point_x = r_px;
    assign o_point_y = r_py;
    assign o_kept    = r_kept;
    assign o_last    = r_last;

endmodule

[design/lidar_point_projection.sv]
// Top level: pose store, distance limit and the rotation cell chain.
//
//   channel   dir  beat contents
//   i_cfg     in   max_distance (16 bit)
//   i_in      in   operation, pose_x/y, pose_heading, distance, scan_angle, scan_end
//   o_out     out  point_x, point_y, kept, last_of_scan
//
// One beat per cycle is accepted while the output is not stalled. A measurement's
// result beat passes through the front register, which loads at its acceptance
// edge, then the register of each rotation cell and then the output register.
// A pose load is applied at its beat and yields no output beat.
// A stalled output freezes the whole chain; i_in.ready follows that stall.
// Synchronous active-low reset clears the pose to zero and the limit to 2000.
`timescale 1ns / 1ps

module lidar_point_projection (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpp_cfg_if.sink   i_cfg,
    lpp_in_if.sink    i_in,
    lpp_out_if.source o_out
);
    import lpp_pkg::*;

    logic                      w_en;
    logic                      w_in_fire;
    logic                      w_cfg_fire;
    logic                      w_out_valid;
    logic signed [COORD_W-1:0] r_hx;
    logic signed [COORD_W-1:0] r_hy;
    logic [ANG_W-1:0]          r_heading;
    logic [DIST_W-1:0]         r_max;
    t_rot                      w_chain [NUM_CELLS+1];

    // Chain advances unless a result beat is waiting
    assign w_en       = !w_out_valid || o_out.ready;
    assign i_in.ready = w_en;
    assign i_cfg.ready = 1'b1;
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_cfg_fire = i_cfg.valid && i_cfg.ready;

    // Hold the distance limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_DIST_RST;
        end else if (w_cfg_fire) begin
            r_max <= i_cfg.max_distance;
        end
    end

    // Hold the robot pose
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hx      <= '0;
            r_hy      <= '0;
            r_heading <= '0;
        end else if (w_in_fire && i_in.operation == OP_POSE) begin
            r_hx      <= i_in.pose_x;
            r_hy      <= i_in.pose_y;
            r_heading <= i_in.pose_heading;
        end
    end

    // Front stage
    lpp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (w_in_fire && i_in.operation == OP_MEAS),
        .i_distance     (i_in.distance),
        .i_scan_angle   (i_in.scan_angle),
        .i_scan_end     (i_in.scan_end),
        .i_heading      (r_heading),
        .i_hx           (r_hx),
        .i_hy           (r_hy),
        .i_max_distance (r_max),
        .o_rot          (w_chain[0])
    );

    // Rotation cell chain
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        lpp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (STAGE_W'(g)),
            .i_rot   (w_chain[g]),
            .o_rot   (w_chain[g+1])
        );
    end

    // Output stage
    lpp_place u_place (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_rot     (w_chain[NUM_CELLS]),
        .o_valid   (w_out_valid),
        .o_point_x (o_out.point_x),
        .o_point_y (o_out.point_y),
        .o_kept    (o_out.kept),
        .o_last    (o_out.last_of_scan)
    );

    assign o_out.valid = w_out_valid;

    // A pose beat lands in the held pose on the next cycle
    a_pose_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in.operation == OP_POSE) |=>
            (r_heading == $past(i_in.pose_heading) && r_hx == $past(i_in.pose_x)
             && r_hy == $past(i_in.pose_y)))
        else $error("pose load not applied");

    // A dropped measurement reports zero coordinates
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.kept) |-> (o_out.point_x == '0 && o_out.point_y == '0))
        else $error("dropped point with nonzero coordinates");

    // A stall freezes the last cell's item
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en) |=> $stable(w_chain[NUM_CELLS]))
        else $error("rotation chain moved while stalled");

    // A configuration beat updates the limit
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_fire |=> (r_max == $past(i_cfg.max_distance)))
        else $error("distance limit not written");

endmodule

[bench/lpp_proj_check_pkg.sv]
// Point tracker: predicts projected points from accepted beats and checks output beats.
`timescale 1ns / 1ps

package lpp_proj_check_pkg;
    import lpp_pkg::*;

    localparam int     TURN_UNITS    = 23040;
    localparam int     HALF_UNITS    = 11520;
    localparam int     QUARTER_UNITS = 5760;
    localparam longint GAIN_COMP     = 39797;
    localparam int     ATAN_LEN      = 24;
    localparam int     CELL_COUNT    = (ROTATION_STAGES < ATAN_LEN) ? ROTATION_STAGES : ATAN_LEN;
    localparam int     Q16_BITS      = 16;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      kept;
        logic                      last;
    } t_point;

    class point_tracker;
        int                mismatches;
        logic [DIST_W-1:0] limit_mm;
        int                held_x;
        int                held_y;
        logic [ANG_W-1:0]  held_heading;
        longint            atan_z [ATAN_LEN];
        t_point            due_points [$];

        function new();
            mismatches   = 0;
            limit_mm     = 16'd2000;
            held_x       = 0;
            held_y       = 0;
            held_heading = '0;
            // atan(2^-i) in 2^-22 degree
            atan_z = '{188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
                       3754631, 1877430, 938729, 469366, 234683, 117342,
                       58671, 29335, 14668, 7334, 3667, 1833,
                       917, 458, 229, 115, 57, 29};
        endfunction

        function void set_limit(input logic [DIST_W-1:0] v);
            limit_mm = v;
        endfunction

        function int outstanding();
            return due_points.size();
        endfunction

        // Fold an angle field into one turn
        local function int fold_angle(input logic [ANG_W-1:0] a);
            int r;
            r = int'(a);
            if (r >= TURN_UNITS)
                r -= TURN_UNITS;
            return r;
        endfunction

        // Round Q16 offset to millimetres, add to the pose and clamp
        local function logic signed [COORD_W-1:0] place(input int held, input longint v);
            longint s;
            s = longint'(held) + ((v + 64'sd32768) >>> Q16_BITS);
            if (s > COORD_MAX)
                s = COORD_MAX;
            if (s < COORD_MIN)
                s = COORD_MIN;
            return s[COORD_W-1:0];
        endfunction

        // Update the pose, or queue the point a measurement should produce
        function void take_input(input logic op,
                                 input logic signed [COORD_W-1:0] px,
                                 input logic signed [COORD_W-1:0] py,
                                 input logic [ANG_W-1:0] hd,
                                 input logic [DIST_W-1:0] range_mm,
                                 input logic [ANG_W-1:0] sa,
                                 input logic se);
            t_point p;
            int     a;
            longint d;
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            if (op == OP_POSE) begin
                held_x       = int'(px);
                held_y       = int'(py);
                held_heading = hd;
                return;
            end
            p.last = se;
            p.kept = 1'b0;
            p.x    = '0;
            p.y    = '0;
            if (range_mm <= limit_mm) begin
                a = fold_angle(held_heading) - fold_angle(sa);
                if (a < 0)
                    a += TURN_UNITS;
                if (a > HALF_UNITS)
                    a -= TURN_UNITS;
                d = longint'(range_mm) * GAIN_COMP;
                // Pre-rotate by a quarter turn when outside the convergence range
                if (a > QUARTER_UNITS) begin
                    x = 0;
                    y = d;
                    a -= QUARTER_UNITS;
                end else if (a < -QUARTER_UNITS) begin
                    x = 0;
                    y = -d;
                    a += QUARTER_UNITS;
                end else begin
                    x = d;
                    y = 0;
                end
                z = longint'(a) * 65536;
                for (int i = 0; i < CELL_COUNT; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (z >= 0) begin
                        x -= dx;
                        y += dy;
                        z -= atan_z[i];
                    end else begin
                        x += dx;
                        y -= dy;
                        z += atan_z[i];
                    end
                end
                p.x    = place(held_x, x);
                p.y    = place(held_y, y);
                p.kept = 1'b1;
            end
            due_points = {due_points, p};
        endfunction

        local function void compare(input string field,
                                    input logic signed [COORD_W-1:0] want,
                                    input logic signed [COORD_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        // Match one output beat against the oldest queued point
        function void check_point(input logic signed [COORD_W-1:0] px,
                                  input logic signed [COORD_W-1:0] py,
                                  input logic kept,
                                  input logic last);
            t_point e;
            if (due_points.size() == 0) begin
                $error("point beat with none due: point_x=%0d point_y=%0d %s=%0b %s=%0b",
                       px, py, "kept", kept, "last_of_scan", last);
                mismatches++;
                return;
            end
            e = due_points.pop_front();
            compare("point_x", e.x, px);
            compare("point_y", e.y, py);
            compare("kept", COORD_W'(e.kept), COORD_W'(kept));
            compare("last_of_scan", COORD_W'(e.last), COORD_W'(last));
        endfunction
    endclass

endpackage

[bench/tb_lidar_point_projection.sv]
// Testbench top: drives pose loads and range measurements, checks every projected point.
`timescale 1ns / 1ps

module tb_lidar_point_projection;
    import lpp_pkg::*;
    import lpp_proj_check_pkg::*;

    localparam int SETTLE_CYCLES = CELL_COUNT + 6;
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_ITEMS  = 650;
    localparam int PHASES        = 5;
    localparam int HALF_PHASE    = RANDOM_ITEMS / (2 * PHASES);

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSE} t_rx_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    t_rx_mode          rx_mode = RX_OPEN;
    int                rx_left = 0;
    int                rx_tick = 0;
    int                idle_cycles = 0;
    logic [DIST_W-1:0] cur_limit = 16'd2000;
    point_tracker      track = new();

    lpp_cfg_if cfg_if ();
    lpp_in_if  in_if ();
    lpp_out_if out_if ();

    lidar_point_projection u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Record accepted beats, check points, end the run on a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                track.set_limit(cfg_if.max_distance);
            if (in_if.valid && in_if.ready)
                track.take_input(in_if.operation, in_if.pose_x, in_if.pose_y,
                                 in_if.pose_heading, in_if.distance,
                                 in_if.scan_angle, in_if.scan_end);
            if (out_if.valid && out_if.ready)
                track.check_point(out_if.point_x, out_if.point_y,
                                  out_if.kept, out_if.last_of_scan);
            if ((cfg_if.valid && cfg_if.ready) || (in_if.valid && in_if.ready)
                    || (out_if.valid && out_if.ready)) begin
                idle_cycles = 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles++;
            end
        end
    end

    // Receiver stall pattern: switch to a new random mode when the current one runs out
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(30, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:  out_if.ready = 1'b1;
            RX_LIGHT: out_if.ready = ($urandom_range(0, 3) != 0);
            RX_HEAVY: out_if.ready = ($urandom_range(0, 3) == 0);
            default:  out_if.ready = (rx_tick % 8 == 0);
        endcase
    end

    // Present one beat and hold it until accepted
    task automatic send_item(input logic op,
                             input logic signed [COORD_W-1:0] px,
                             input logic signed [COORD_W-1:0] py,
                             input logic [ANG_W-1:0] hd,
                             input logic [DIST_W-1:0] range_mm,
                             input logic [ANG_W-1:0] sa,
                             input logic se);
        @(negedge i_clk);
        in_if.valid        = 1'b1;
        in_if.operation    = op;
        in_if.pose_x       = px;
        in_if.pose_y       = py;
        in_if.pose_heading = hd;
        in_if.distance     = range_mm;
        in_if.scan_angle   = sa;
        in_if.scan_end     = se;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic send_pose(input logic signed [COORD_W-1:0] px,
                             input logic signed [COORD_W-1:0] py,
                             input logic [ANG_W-1:0] hd);
        send_item(OP_POSE, px, py, hd, DIST_W'($urandom), ANG_W'($urandom),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic send_meas(input logic [DIST_W-1:0] range_mm, input logic [ANG_W-1:0] sa,
                             input logic se);
        send_item(OP_MEAS, COORD_W'($urandom), COORD_W'($urandom), ANG_W'($urandom),
                  range_mm, sa, se);
    endtask

    // Drop valid for the given gap
    task automatic pause_sender(input int gap);
        @(negedge i_clk);
        in_if.valid = 1'b0;
        repeat (gap - 1) @(negedge i_clk);
    endtask

    // Hold the sender until every due point has come and the chain is empty
    task automatic settle();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (track.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [DIST_W-1:0] v);
        settle();
        @(negedge i_clk);
        cfg_if.valid        = 1'b1;
        cfg_if.max_distance = v;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
        cur_limit    = v;
    endtask

    // Mostly measurements; distances cluster around the limit and near zero
    task automatic send_random_item();
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic [ANG_W-1:0]          hd;
        logic [ANG_W-1:0]          sa;
        logic [DIST_W-1:0]         range_mm;
        int                        near;
        px = COORD_W'($urandom);
        py = COORD_W'($urandom);
        hd = ($urandom_range(0, 7) == 0) ? ANG_W'($urandom)
                                         : ANG_W'($urandom_range(0, 23039));
        if ($urandom_range(0, 7) == 0) begin
            // Put the pose near an edge now and then to reach saturation
            case ($urandom_range(0, 3))
                0: px = COORD_W'(COORD_MAX - int'($urandom_range(0, 65535)));
                1: px = COORD_W'(COORD_MIN + int'($urandom_range(0, 65535)));
                2: py = COORD_W'(COORD_MAX - int'($urandom_range(0, 65535)));
                default: py = COORD_W'(COORD_MIN + int'($urandom_range(0, 65535)));
            endcase
            send_pose(px, py, hd);
            return;
        end
        case ($urandom_range(0, 3))
            0: range_mm = DIST_W'($urandom_range(0, cur_limit));
            1: range_mm = DIST_W'($urandom);
            2: begin
                near = int'(cur_limit) + int'($urandom_range(0, 2)) - 1;
                if (near < 0)
                    near = 0;
                if (near > 65535)
                    near = 65535;
                range_mm = DIST_W'(near);
            end
            default: range_mm = DIST_W'($urandom_range(0, 300));
        endcase
        case ($urandom_range(0, 7))
            0: sa = ANG_W'($urandom);
            1: sa = ANG_W'($urandom_range(0, 3) * 5760 + $urandom_range(0, 2));
            default: sa = ANG_W'($urandom_range(0, 23039));
        endcase
        send_meas(range_mm, sa, $urandom_range(0, 7) == 0);
    endtask

    // Bursts of random length with random gaps, some stretches gap-free
    task automatic run_bursts(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_random_item();
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.max_distance = '0;
        in_if.valid         = 1'b0;
        in_if.operation     = OP_POSE;
        in_if.pose_x        = '0;
        in_if.pose_y        = '0;
        in_if.pose_heading  = '0;
        in_if.distance      = '0;
        in_if.scan_angle    = '0;
        in_if.scan_end      = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset pose and limit: zero range, limit edge, dropped ranges
        send_meas(16'd0, 15'd0, 1'b0);
        send_meas(16'd2000, 15'd0, 1'b0);
        send_meas(16'd2001, 15'd100, 1'b1);
        send_meas(16'd65535, 15'd23039, 1'b0);
        // Pose at the corners: saturate both ways, quarter and half turn edges
        send_pose(24'sh7FFFFF, 24'sh800000, 15'd0);
        send_meas(16'd2000, 15'd0, 1'b0);
        send_meas(16'd2000, 15'd5760, 1'b0);
        send_meas(16'd1500, 15'd5759, 1'b0);
        send_meas(16'd1500, 15'd17280, 1'b0);
        send_meas(16'd1500, 15'd17279, 1'b1);
        send_meas(16'd1999, 15'd11520, 1'b0);
        send_meas(16'd1999, 15'd11521, 1'b0);
        // Angle fields past a full turn fold back
        send_pose(24'sh800000, 24'sh7FFFFF, 15'h7FFF);
        send_meas(16'd2000, 15'h7FFF, 1'b1);
        send_meas(16'd1999, 15'd23040, 1'b0);
        send_pose(24'sd0, 24'sd0, 15'd23039);
        send_meas(16'd1, 15'd0, 1'b0);
        send_meas(16'd1234, 15'd23039, 1'b1);
        // Widest limit, then the narrowest
        write_limit(16'd65535);
        send_meas(16'd65535, 15'd5000, 1'b1);
        send_pose(24'sd1234, -24'sd4321, 15'd11520);
        send_meas(16'd65535, 15'd0, 1'b0);
        write_limit(16'd0);
        send_meas(16'd0, 15'd8000, 1'b0);
        send_meas(16'd1, 15'd8000, 1'b1);

        // Random phases, each under its own limit, with a drain mid-phase
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: write_limit(DIST_W'($urandom_range(0, 65535)));
                1: write_limit(16'd65535);
                2: write_limit(16'd1500);
                3: write_limit(DIST_W'($urandom_range(0, 255)));
                default: write_limit(16'd2000);
            endcase
            run_bursts(HALF_PHASE);
            settle();
            run_bursts(HALF_PHASE);
        end

        settle();
        if (track.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
